### hdl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// shared types, codes and helpers of the fixed block free list pool
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

    localparam int POOL_BLOCKS_DEF = 255;

    // request kinds
    localparam logic [1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    // result status
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_OWNED = 2'd2;
    localparam logic [1:0] STAT_NONE_USED = 2'd3;

    // address classes
    localparam logic [1:0] OWN_BELOW  = 2'd0;
    localparam logic [1:0] OWN_INSIDE = 2'd1;
    localparam logic [1:0] OWN_ABOVE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_SHIFT = 2'd1;
    localparam logic [1:0] CFG_CHUNK = 2'd2;

    localparam logic [63:0] BASE_RST  = 64'd0;
    localparam logic [4:0]  SHIFT_RST = 5'd4;
    localparam logic [31:0] CHUNK_RST = 32'd4096;

    localparam int SPAN_W = 39;

    typedef enum logic {
        FSM_IDLE,
        FSM_ACQ
    } fsm_state_t;

    typedef struct packed {
        logic [63:0]       base;
        logic [4:0]        shift;
        logic [SPAN_W-1:0] span;
        logic [31:0]       mask;
    } pool_cfg_t;

    typedef struct packed {
        logic       below;
        logic       in_pool;
        logic       aligned;
        logic [7:0] idx;
    } addr_info_t;

    function automatic logic [7:0] pool_count(input logic [31:0] chunk,
                                              input logic [4:0]  shift,
                                              input logic [7:0]  maxb);
        logic [31:0] n;
        n = chunk >> shift;
        if (n < {24'd0, maxb}) begin
            return n[7:0];
        end
        return maxb;
    endfunction

endpackage

`default_nettype wire

### hdl/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/fbfl_cfg.sv
// ----------------------------------------------------------------------------
// fbfl_cfg
// configuration registers and the pool geometry derived from them
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_cfg #(
    parameter int POOL_BLOCKS = fbfl_pkg::POOL_BLOCKS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_index,
    input  wire logic [63:0]       cfg_wr_data,
    output fbfl_pkg::pool_cfg_t    cfg,
    output logic                   rebuild,
    output logic [7:0]             rebuild_count
);

    localparam logic [7:0] MAX_B = 8'(POOL_BLOCKS);

    logic [63:0] base_reg,  base_next;
    logic [4:0]  shift_reg, shift_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [7:0]  count_next;
    logic [fbfl_pkg::SPAN_W-1:0] span_reg, span_next;
    logic [31:0] mask_reg,  mask_next;

    always_comb begin
        base_next  = base_reg;
        shift_next = shift_reg;
        chunk_next = chunk_reg;
        rebuild    = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                fbfl_pkg::CFG_BASE: begin
                    base_next = cfg_wr_data;
                    rebuild   = 1'b1;
                end
                fbfl_pkg::CFG_SHIFT: begin
                    shift_next = cfg_wr_data[4:0];
                    rebuild    = 1'b1;
                end
                fbfl_pkg::CFG_CHUNK: begin
                    chunk_next = cfg_wr_data[31:0];
                    rebuild    = 1'b1;
                end
                default: begin
                    rebuild = 1'b0;
                end
            endcase
        end
        count_next = fbfl_pkg::pool_count(chunk_next, shift_next, MAX_B);
        span_next  = {{(fbfl_pkg::SPAN_W-8){1'b0}}, count_next} << shift_next;
        mask_next  = (32'd1 << shift_next) - 32'd1;
    end

    assign rebuild_count = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= fbfl_pkg::BASE_RST;
            shift_reg <= fbfl_pkg::SHIFT_RST;
            chunk_reg <= fbfl_pkg::CHUNK_RST;
            span_reg  <= {{(fbfl_pkg::SPAN_W-8){1'b0}},
                          fbfl_pkg::pool_count(fbfl_pkg::CHUNK_RST, fbfl_pkg::SHIFT_RST,
                                               MAX_B)} << fbfl_pkg::SHIFT_RST;
            mask_reg  <= (32'd1 << fbfl_pkg::SHIFT_RST) - 32'd1;
        end else begin
            base_reg  <= base_next;
            shift_reg <= shift_next;
            chunk_reg <= chunk_next;
            span_reg  <= span_next;
            mask_reg  <= mask_next;
        end
    end

    always_comb begin
        cfg.base  = base_reg;
        cfg.shift = shift_reg;
        cfg.span  = span_reg;
        cfg.mask  = mask_reg;
    end

endmodule

`default_nettype wire

### hdl/fbfl_addr_check.sv
// ----------------------------------------------------------------------------
// fbfl_addr_check
// classifies an address against the pool and finds its block index
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_addr_check (
    input  wire fbfl_pkg::pool_cfg_t cfg,
    input  wire logic [63:0]         address,
    output fbfl_pkg::addr_info_t     info
);

    logic [64:0] diff;
    logic [63:0] offset;
    logic [63:0] blk;

    always_comb begin
        diff   = {1'b0, address} - {1'b0, cfg.base};
        offset = diff[63:0];
        blk    = offset >> cfg.shift;
        info.below   = diff[64];
        info.in_pool = !diff[64] &&
                       (offset < {{(64-fbfl_pkg::SPAN_W){1'b0}}, cfg.span});
        info.aligned = info.in_pool && ((offset[31:0] & cfg.mask) == 32'd0);
        info.idx     = blk[7:0];
    end

endmodule

`default_nettype wire

### hdl/fixed_block_free_list_pool_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_pool_unit
// pool of equal power-of-two blocks kept on a linked free list of indices
//
//   channel  dir  bus                         content
//   s_       in   tdata 64, tuser 2           request address, request kind
//   m_       out  tdata 80                    one result per request
//   cfg_wr_  in   en, index 2, data 64        base, block shift, chunk bytes
//
// acquire passes through the ACQ state: the link of the head comes from the link table ram
// through its registered read port; release, query and unknown kinds stay in IDLE
// synchronous active-low reset; link entries carry valid bits, no clearing pass
// a held result blocks further transfers until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_pool_unit #(
    parameter int POOL_BLOCKS = fbfl_pkg::POOL_BLOCKS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // address
    input  wire logic [1:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata,   // status, block_address, ownership,
                                        // owned_aligned, pool_all_free, free_count
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [63:0] cfg_wr_data
);

    localparam int         ADDR_W = $clog2(POOL_BLOCKS);
    localparam logic [7:0] MAX_B  = 8'(POOL_BLOCKS);

    fbfl_pkg::pool_cfg_t  cfg;
    fbfl_pkg::addr_info_t info;
    fbfl_pkg::fsm_state_t state_reg, state_next;

    logic              rebuild;
    logic [7:0]        rebuild_count;

    logic [7:0]        free_head_reg,   free_head_next;
    logic [7:0]        blocks_free_reg, blocks_free_next;
    logic [7:0]        blocks_used_reg, blocks_used_next;
    logic [POOL_BLOCKS-1:0] link_valid_reg, link_valid_next;
    logic              acq_use_ram_reg, acq_use_ram_next;
    logic [7:0]        acq_alt_reg,     acq_alt_next;
    logic              m_tvalid_reg,    m_tvalid_next;
    logic [79:0]       m_tdata_reg,     m_tdata_next;

    logic              accept;
    logic              acq_done;
    logic              head_in_range;
    logic              head_valid;
    logic              ram_rd_en;
    logic              ram_wr_en;
    logic [7:0]        ram_rd_data;

    logic [1:0]        r_status;
    logic [63:0]       r_baddr;
    logic [1:0]        r_own;
    logic              r_aligned;
    logic              r_allfree;
    logic              pop;
    logic              push;

    fbfl_cfg #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .cfg           (cfg),
        .rebuild       (rebuild),
        .rebuild_count (rebuild_count)
    );

    fbfl_addr_check u_check (
        .cfg     (cfg),
        .address (s_tdata),
        .info    (info)
    );

    fbfl_ram #(
        .WIDTH (8),
        .DEPTH (POOL_BLOCKS)
    ) u_link_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (info.idx[ADDR_W-1:0]),
        .wr_data (free_head_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (free_head_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fbfl_pkg::FSM_IDLE: begin
                if (pop) begin
                    state_next = fbfl_pkg::FSM_ACQ;
                end
            end
            fbfl_pkg::FSM_ACQ: begin
                state_next = fbfl_pkg::FSM_IDLE;
            end
            default: begin
                state_next = fbfl_pkg::FSM_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        acq_done = 1'b0;
        case (state_reg)
            fbfl_pkg::FSM_IDLE: begin
                s_tready = !m_tvalid_reg || m_tready;
            end
            fbfl_pkg::FSM_ACQ: begin
                acq_done = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept        = s_tvalid && s_tready;
    assign head_in_range = free_head_reg < MAX_B;
    assign head_valid    = head_in_range && link_valid_reg[free_head_reg[ADDR_W-1:0]];

    always_comb begin
        r_status  = fbfl_pkg::STAT_OK;
        r_baddr   = 64'd0;
        r_own     = fbfl_pkg::OWN_BELOW;
        r_aligned = 1'b0;
        r_allfree = 1'b0;
        pop       = 1'b0;
        push      = 1'b0;
        if (accept) begin
            case (s_tuser)
                fbfl_pkg::REQ_ACQUIRE: begin
                    if (blocks_free_reg == 8'd0) begin
                        r_status = fbfl_pkg::STAT_EMPTY;
                    end else begin
                        pop     = 1'b1;
                        r_baddr = cfg.base + ({56'd0, free_head_reg} << cfg.shift);
                    end
                end
                fbfl_pkg::REQ_RELEASE, fbfl_pkg::REQ_QUERY: begin
                    r_aligned = info.aligned;
                    if (info.below) begin
                        r_own = fbfl_pkg::OWN_BELOW;
                    end else if (info.in_pool) begin
                        r_own = fbfl_pkg::OWN_INSIDE;
                    end else begin
                        r_own = fbfl_pkg::OWN_ABOVE;
                    end
                    if (s_tuser == fbfl_pkg::REQ_RELEASE) begin
                        if (!info.aligned) begin
                            r_status = fbfl_pkg::STAT_NOT_OWNED;
                        end else if (blocks_used_reg == 8'd0) begin
                            r_status = fbfl_pkg::STAT_NONE_USED;
                        end else begin
                            push      = 1'b1;
                            r_allfree = blocks_used_reg == 8'd1;
                        end
                    end
                end
                default: begin
                    r_status = fbfl_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign ram_rd_en = pop && head_in_range;
    assign ram_wr_en = push;

    always_comb begin
        free_head_next   = free_head_reg;
        blocks_free_next = blocks_free_reg;
        blocks_used_next = blocks_used_reg;
        link_valid_next  = link_valid_reg;
        acq_use_ram_next = acq_use_ram_reg;
        acq_alt_next     = acq_alt_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (pop) begin
            blocks_free_next = blocks_free_reg - 8'd1;
            blocks_used_next = blocks_used_reg + 8'd1;
            acq_use_ram_next = head_valid;
            acq_alt_next     = head_in_range ? free_head_reg + 8'd1 : 8'd0;
        end
        if (push) begin
            blocks_free_next = blocks_free_reg + 8'd1;
            blocks_used_next = blocks_used_reg - 8'd1;
            free_head_next   = info.idx;
            link_valid_next[info.idx[ADDR_W-1:0]] = 1'b1;
        end
        if (acq_done) begin
            free_head_next = acq_use_ram_reg ? ram_rd_data : acq_alt_reg;
        end
        if (rebuild) begin
            free_head_next   = 8'd0;
            blocks_free_next = rebuild_count;
            blocks_used_next = 8'd0;
            link_valid_next  = '0;
        end

        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, blocks_free_next, r_allfree, r_aligned, r_own,
                             r_baddr, r_status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fbfl_pkg::FSM_IDLE;
            free_head_reg   <= 8'd0;
            blocks_free_reg <= fbfl_pkg::pool_count(fbfl_pkg::CHUNK_RST,
                                                    fbfl_pkg::SHIFT_RST, MAX_B);
            blocks_used_reg <= 8'd0;
            link_valid_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            free_head_reg   <= free_head_next;
            blocks_free_reg <= blocks_free_next;
            blocks_used_reg <= blocks_used_next;
            link_valid_reg  <= link_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acq_use_ram_reg <= acq_use_ram_next;
        acq_alt_reg     <= acq_alt_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
